>>> hw/rtl/connection_idle_timing_wheel_macros.svh
// Assertion macros used by the timing wheel checker.
`ifndef CONNECTION_IDLE_TIMING_WHEEL_MACROS_SVH
`define CONNECTION_IDLE_TIMING_WHEEL_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CIT_ASSERT_IMPL(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CIT_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cit_pkg.sv
// Shared types and constants of the connection idle timing wheel.
`timescale 1ns / 1ps
`default_nettype none
package cit_pkg;

	localparam int IdW      = 6;
	localparam int SlotW    = 6;
	localparam int OpW      = 2;
	localparam int SlotCntW = 7;
	localparam int TimeoutW = 6;
	localparam int DataW    = 32;
	localparam int AddrW    = 3;

	localparam logic REG_SLOT_COUNT = 1'b0;
	localparam logic REG_TIMEOUT    = 1'b1;

	typedef enum logic [OpW-1:0] {
		OP_TOUCH  = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t        op;
		logic [IdW-1:0] id;
	} cmd_t;

	typedef struct packed {
		logic [IdW-1:0] id;
		logic           none;
		logic           last;
	} res_t;

	// Effective configuration, already clamped to legal ranges.
	typedef struct packed {
		logic [SlotCntW-1:0] slots;
		logic [TimeoutW-1:0] timeout;
	} cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/cit_fifo.sv
// Small register FIFO used for the command and result queues.
`timescale 1ns / 1ps
`default_nettype none
module cit_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CntW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_rd) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

>>> hw/rtl/cit_front.sv
// Front end: accepts requests, drops no-ops, queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module cit_front #(
	parameter int MAX_CONNS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [cit_pkg::OpW-1:0] opcode,
	input  logic [cit_pkg::IdW-1:0] conn_id,
	input  logic                   cmd_pop,
	output logic                   cmd_empty,
	output cit_pkg::cmd_t          cmd_head
);
	import cit_pkg::*;

	logic                 keep;
	cmd_t                 cmd_in;
	logic [$bits(cmd_t)-1:0] head_bits;

	always_comb begin
		unique case (opcode) inside
			OP_TOUCH, OP_REMOVE: keep = ({1'b0, conn_id} < (IdW + 1)'(MAX_CONNS));
			OP_TICK:             keep = 1'b1;
			default:             keep = 1'b0;
		endcase
	end

	assign cmd_in   = '{op: cmd_op_t'(opcode), id: conn_id};
	assign cmd_head = cmd_t'(head_bits);

	// A dropped request is still accepted; it just never enters the queue.
	cit_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push && keep),
		.wr_data(cmd_in),
		.full   (full),
		.rd_en  (cmd_pop),
		.rd_data(head_bits),
		.empty  (cmd_empty)
	);

endmodule
`default_nettype wire

>>> hw/rtl/cit_mod_unit.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cit_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cit_pkg::SlotCntW-1:0] dividend,
	input  logic [cit_pkg::SlotCntW-1:0] divisor,
	output logic                        done,
	output logic [cit_pkg::SlotW-1:0]    rem
);
	import cit_pkg::*;

	localparam int StepW = $clog2(SlotCntW);

	logic [SlotCntW-1:0] a_q, n_q, r_q, sh, nxt;
	logic [StepW-1:0]    cnt_q;
	logic                busy_q;

	assign sh   = {r_q[SlotCntW-2:0], a_q[SlotCntW-1]};
	assign nxt  = (sh >= n_q) ? sh - n_q : sh;
	// Remainder is below the divisor, which the top level clamps to MAX_SLOTS (64 by default).
	assign rem  = r_q[SlotW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= StepW'(SlotCntW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= dividend;
			n_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[SlotCntW-2:0], 1'b0};
			r_q <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cit_back.sv
// Back end: executes touch, remove and tick against the slot table.
`timescale 1ns / 1ps
`default_nettype none
module cit_back #(
	parameter int MAX_CONNS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cit_pkg::cfg_t          cfg,
	input  logic                   cmd_empty,
	input  cit_pkg::cmd_t          cmd_head,
	output logic                   cmd_pop,
	input  logic                   pop,
	output logic                   empty,
	output logic [cit_pkg::IdW-1:0] expired_id,
	output logic                   none_expired,
	output logic                   last
);
	import cit_pkg::*;

	localparam int IdxW = $clog2(MAX_CONNS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_RD,
		ST_CHK,
		ST_FLUSH
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [SlotW-1:0]    cur_q;
	logic [IdxW-1:0]     idx_q, pend_q;
	logic                have_pend_q;
	logic                valid_q [MAX_CONNS];
	logic [SlotW-1:0]    slot_mem [MAX_CONNS];
	logic [SlotW-1:0]    rd_q;

	logic                mod_start, mod_done;
	logic [SlotCntW-1:0] dividend;
	logic [SlotW-1:0]    mod_rem;
	logic                hit, mem_we;
	logic                res_wr, res_full;
	res_t                res_in;
	logic [$bits(res_t)-1:0] res_bits;
	res_t                res_head;

	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign mod_start = cmd_pop && (cmd_head.op != OP_REMOVE);
	assign dividend  = (cmd_head.op == OP_TICK)
		? {1'b0, cur_q} + SlotCntW'(1)
		: {1'b0, cur_q} + SlotCntW'(cfg.timeout);
	assign mem_we    = (state_q == ST_MOD) && mod_done && (cmd_q.op == OP_TOUCH);
	assign hit       = valid_q[idx_q] && (rd_q == cur_q);

	cit_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(dividend),
		.divisor (cfg.slots),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// A hit first flushes the held result, so last can be set on the final one.
	always_comb begin
		res_wr = 1'b0;
		res_in = '{id: IdW'(pend_q), none: 1'b0, last: 1'b0};
		if (state_q == ST_CHK) begin
			res_wr = hit && have_pend_q;
		end else if (state_q == ST_FLUSH) begin
			res_wr = 1'b1;
			if (have_pend_q) res_in = '{id: IdW'(pend_q), none: 1'b0, last: 1'b1};
			else             res_in = '{id: '0, none: 1'b1, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '{op: OP_TICK, id: '0};
			cur_q       <= '0;
			idx_q       <= '0;
			pend_q      <= '0;
			have_pend_q <= 1'b0;
			for (int i = 0; i < MAX_CONNS; i++) valid_q[i] <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd_head;
						if (cmd_head.op == OP_REMOVE) valid_q[cmd_head.id[IdxW-1:0]] <= 1'b0;
						else                          state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						if (cmd_q.op == OP_TOUCH) begin
							valid_q[cmd_q.id[IdxW-1:0]] <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							cur_q   <= mod_rem;
							idx_q   <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: state_q <= ST_CHK;
				ST_CHK: begin
					if (!(res_wr && res_full)) begin
						if (hit) begin
							valid_q[idx_q] <= 1'b0;
							pend_q         <= idx_q;
							have_pend_q    <= 1'b1;
						end
						if (idx_q == IdxW'(MAX_CONNS - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_FLUSH: begin
					if (!res_full) begin
						have_pend_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) slot_mem[cmd_q.id[IdxW-1:0]] <= mod_rem;
		if (state_q == ST_RD) rd_q <= slot_mem[idx_q];
	end

	cit_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_wr && !res_full),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_bits),
		.empty  (empty)
	);

	assign res_head     = res_t'(res_bits);
	assign expired_id   = res_head.id;
	assign none_expired = res_head.none;
	assign last         = res_head.last;

endmodule
`default_nettype wire

>>> hw/rtl/connection_idle_timing_wheel.sv
// Connection idle timing wheel: touch, remove and tick requests on a queue-style input,
// expired connections on a queue-style output, slot count and timeout over APB.
// Requests pass a two-deep command queue to a sequential executor. A remove is applied
// as it is popped; a touch waits for its slot, computed by a 7-step iterative remainder
// unit. A tick also computes its slot, then scans the single-port slot table, one
// entry per read/check pair, and stalls while the two-deep result queue is full. Results
// of one tick come in ascending id order with last on the final one; an empty tick gives
// one result with none_expired set. No clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none
module connection_idle_timing_wheel #(
	parameter int MAX_CONNS = 64,
	parameter int MAX_SLOTS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [cit_pkg::OpW-1:0]   opcode,
	input  logic [cit_pkg::IdW-1:0]   conn_id,
	output logic                     empty,
	input  logic                     pop,
	output logic [cit_pkg::IdW-1:0]   expired_id,
	output logic                     none_expired,
	output logic                     last,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [cit_pkg::AddrW-1:0] paddr,
	input  logic [cit_pkg::DataW-1:0] pwdata,
	output logic [cit_pkg::DataW-1:0] prdata,
	output logic                     pready
);
	import cit_pkg::*;

	localparam logic [SlotCntW-1:0] MaxSlots = SlotCntW'(MAX_SLOTS);

	logic [SlotCntW-1:0] slot_count_q;
	logic [TimeoutW-1:0] timeout_q;
	logic                cfg_wr;
	cfg_t                cfg;
	logic                cmd_pop, cmd_empty;
	cmd_t                cmd_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SlotCntW'(8);
			timeout_q    <= TimeoutW'(1);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SLOT_COUNT: slot_count_q <= pwdata[SlotCntW-1:0];
				REG_TIMEOUT:    timeout_q    <= pwdata[TimeoutW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SLOT_COUNT: prdata = DataW'(slot_count_q);
			REG_TIMEOUT:    prdata = DataW'(timeout_q);
			default:        prdata = '0;
		endcase
	end

	// Zero means one; counts beyond the wheel saturate.
	always_comb begin
		if (slot_count_q == '0)         cfg.slots = SlotCntW'(1);
		else if (slot_count_q > MaxSlots) cfg.slots = MaxSlots;
		else                            cfg.slots = slot_count_q;
		cfg.timeout = (timeout_q == '0) ? TimeoutW'(1) : timeout_q;
	end

	cit_front #(.MAX_CONNS(MAX_CONNS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.conn_id  (conn_id),
		.cmd_pop  (cmd_pop),
		.cmd_empty(cmd_empty),
		.cmd_head (cmd_head)
	);

	cit_back #(.MAX_CONNS(MAX_CONNS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd_empty   (cmd_empty),
		.cmd_head    (cmd_head),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.expired_id  (expired_id),
		.none_expired(none_expired),
		.last        (last)
	);

endmodule
`default_nettype wire

>>> hw/rtl/cit_checker.sv
// Port-level checker for the connection idle timing wheel, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "connection_idle_timing_wheel_macros.svh"
module cit_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     psel,
	input logic                     penable,
	input logic                     pwrite,
	input logic [cit_pkg::AddrW-1:0] paddr,
	input logic [cit_pkg::DataW-1:0] pwdata,
	input logic [cit_pkg::DataW-1:0] prdata,
	input logic                     pready,
	input logic                     empty,
	input logic                     pop,
	input logic [cit_pkg::IdW-1:0]   expired_id,
	input logic                     none_expired,
	input logic                     last
);
	import cit_pkg::*;

	`CIT_ASSERT_IMPL(a_pready_high, 1'b1, pready, "pready dropped")

	// An empty tick is always a single, final result with id zero.
	`CIT_ASSERT_IMPL(a_none_is_last, !empty && none_expired,
		last && (expired_id == '0), "none_expired result malformed")

	`CIT_ASSERT_NEXT(a_res_hold, !empty && !pop,
		!empty && $stable(expired_id) && $stable(none_expired) && $stable(last),
		"waiting result changed")

	// Slot count reads back what was just written.
	`CIT_ASSERT_IMPL(a_slot_readback,
		(psel && penable && pwrite && (paddr[2] == REG_SLOT_COUNT)) ##1
		(psel && !pwrite && (paddr[2] == REG_SLOT_COUNT)),
		prdata[SlotCntW-1:0] == $past(pwdata[SlotCntW-1:0]), "slot count readback")

endmodule

bind connection_idle_timing_wheel cit_checker u_checker (.*);
`default_nettype wire
